### hw/rtl/nhbl_pkg.sv
`timescale 1ns / 1ps

package nhbl_pkg;

    // Widths of the configuration registers and of the payload fields.
    localparam int unsigned POLL_W  = 16;
    localparam int unsigned TRIES_W = 5;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LINE_W  = 2;
    localparam int unsigned PORT_W  = 4;

    // Configuration register indexes.
    localparam logic CFG_POLL_LIMIT    = 1'b0;
    localparam logic CFG_REQUEST_TRIES = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [POLL_W-1:0]  POLL_LIMIT_RST    = 16'd20000;
    localparam logic [TRIES_W-1:0] REQUEST_TRIES_RST = 5'd20;

    // Operation codes carried by each input word.
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND = 2'd1;
    localparam logic [OP_W-1:0] OP_RECV = 2'd2;

    // One result word.
    typedef struct packed {
        logic [PORT_W-1:0] port_out;
        logic              busy_res;
        logic              done_res;
        logic              timeout_error;
        logic [BYTE_W-1:0] rx_byte;
    } t_result;

endpackage

### hw/rtl/nibble_handshake_byte_link.sv
`timescale 1ns / 1ps

// Handshaked byte link toward a partner over four data lines out and two
// status lines in. Every input word is one tick: it carries a request
// (tick only, send a byte, receive a byte) and the partner lines sampled
// for that tick, and it produces exactly one result word with the value
// to drive on the data lines plus busy, done, timeout and received-byte
// status. Requests arriving while a transfer runs are ignored. The block
// takes one word per clock unless stalled: the sequencer state advances
// on the accepting edge and the result word is captured in the output
// register on that same edge, so it is offered in the next cycle, and a
// new word is accepted in the same cycle that the previous result is
// taken. Input stall is raised only while a result sits in the output
// register and the consumer stalls it. The user must write the poll
// limit and the number of receive-request tries through the configuration
// port only while the link is idle; the block does not enforce it. A wait
// phase that sees no matching line state within the poll limit times out.
module nibble_handshake_byte_link (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port.
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [nhbl_pkg::CFG_W-1:0]      i_cfg_data,
    // Input words.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [nhbl_pkg::OP_W-1:0]       i_op,
    input  logic [nhbl_pkg::BYTE_W-1:0]     i_tx_byte,
    input  logic [nhbl_pkg::LINE_W-1:0]     i_line_state,
    // Result words.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [nhbl_pkg::PORT_W-1:0]     o_port_out,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic                            o_timeout_error,
    output logic [nhbl_pkg::BYTE_W-1:0]     o_rx_byte
);
    import nhbl_pkg::*;

    logic [POLL_W-1:0]  r_poll_limit;
    logic [TRIES_W-1:0] r_request_tries;
    logic               r_out_valid;
    t_result            r_res;
    t_result            core_res;
    logic               accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit    <= POLL_LIMIT_RST;
            r_request_tries <= REQUEST_TRIES_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_POLL_LIMIT:    r_poll_limit    <= i_cfg_data[POLL_W-1:0];
                CFG_REQUEST_TRIES: r_request_tries <= i_cfg_data[TRIES_W-1:0];
                default:           r_poll_limit    <= r_poll_limit;
            endcase
        end
    end

    // The output register frees up in the same cycle its word is taken.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    nhbl_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (accept),
        .i_op            (i_op),
        .i_tx_byte       (i_tx_byte),
        .i_line_state    (i_line_state),
        .i_poll_limit    (r_poll_limit),
        .i_request_tries (r_request_tries),
        .o_res           (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= core_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_port_out      = r_res.port_out;
    assign o_busy_res      = r_res.busy_res;
    assign o_done_res      = r_res.done_res;
    assign o_timeout_error = r_res.timeout_error;
    assign o_rx_byte       = r_res.rx_byte;

    // A finishing word never also reports busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.done_res && r_res.busy_res))
        else $error("done and busy reported together");

    // A timeout is only flagged on the word that ends a transfer.
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.timeout_error) |-> r_res.done_res)
        else $error("timeout without done");

    // A received byte shows only on a successful finish.
    a_rx_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.rx_byte != '0)) |->
            (r_res.done_res && !r_res.timeout_error))
        else $error("received byte outside a successful finish");

    // A word of a running transfer carries no finishing status.
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && core_res.busy_res) |->
            (!core_res.done_res && !core_res.timeout_error && (core_res.rx_byte == '0)))
        else $error("finishing status reported while busy");

endmodule

### hw/rtl/nhbl_core.sv
`timescale 1ns / 1ps

module nhbl_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [nhbl_pkg::OP_W-1:0]       i_op,
    input  logic [nhbl_pkg::BYTE_W-1:0]     i_tx_byte,
    input  logic [nhbl_pkg::LINE_W-1:0]     i_line_state,
    input  logic [nhbl_pkg::POLL_W-1:0]     i_poll_limit,
    input  logic [nhbl_pkg::TRIES_W-1:0]    i_request_tries,
    output nhbl_pkg::t_result               o_res
);
    import nhbl_pkg::*;

    // One state per output step of the link protocol.
    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0_0000_0000_0001,
        ST_TX_REQ    = 13'b0_0000_0000_0010,
        ST_TX_LO     = 13'b0_0000_0000_0100,
        ST_TX_MID    = 13'b0_0000_0000_1000,
        ST_TX_HI     = 13'b0_0000_0001_0000,
        ST_RX_REQ_A  = 13'b0_0000_0010_0000,
        ST_RX_REQ_B  = 13'b0_0000_0100_0000,
        ST_RX_BIT    = 13'b0_0000_1000_0000,
        ST_RX_ACK0   = 13'b0_0001_0000_0000,
        ST_RX_ACK1_A = 13'b0_0010_0000_0000,
        ST_RX_ACK1_B = 13'b0_0100_0000_0000,
        ST_RX_ACK1_C = 13'b0_1000_0000_0000,
        ST_RX_END    = 13'b1_0000_0000_0000
    } t_step;

    localparam logic [PORT_W-1:0] PV_TX_REQ   = 4'h9;
    localparam logic [PORT_W-1:0] PV_RX_REQ_A = 4'hB;
    localparam logic [PORT_W-1:0] PV_RX_REQ_B = 4'hF;
    localparam logic [PORT_W-1:0] PV_RX_BIT   = 4'hC;
    localparam logic [PORT_W-1:0] PV_ACK0     = 4'hD;
    localparam logic [PORT_W-1:0] PV_ACK1_A   = 4'hE;
    localparam logic [PORT_W-1:0] PV_ACK1_B   = 4'hA;
    localparam logic [PORT_W-1:0] PV_ACK1_C   = 4'h8;

    localparam logic [LINE_W-1:0] LS_ZERO = 2'd0;
    localparam logic [LINE_W-1:0] LS_CLR  = 2'd2;
    localparam logic [LINE_W-1:0] LS_BOTH = 2'd3;

    t_step                r_step,       n_step;
    logic                 r_wait,       n_wait;
    logic [PORT_W-1:0]    r_port_latch, n_port_latch;
    logic [POLL_W-1:0]    r_poll,       n_poll;
    logic [TRIES_W-1:0]   r_try,        n_try;
    logic [2:0]           r_bit,        n_bit;
    logic [BYTE_W-1:0]    r_shift,      n_shift;
    logic [BYTE_W-1:0]    r_tx,         n_tx;
    t_result              res;

    always_comb begin
        t_step             step;
        logic [PORT_W-1:0] value;
        logic [LINE_W-1:0] target;
        logic              hit;
        logic              poll_out;
        logic [TRIES_W-1:0] try_inc;

        n_step       = r_step;
        n_wait       = r_wait;
        n_port_latch = r_port_latch;
        n_poll       = r_poll;
        n_try        = r_try;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_tx         = r_tx;
        res.port_out      = r_port_latch;
        res.busy_res      = 1'b1;
        res.done_res      = 1'b0;
        res.timeout_error = 1'b0;
        res.rx_byte       = '0;
        value    = PV_RX_BIT;
        target   = LS_ZERO;
        hit      = 1'b0;
        try_inc  = r_try + 1'b1;
        poll_out = ({1'b0, r_poll} + 17'd1) >= {1'b0, i_poll_limit};

        // A request is taken only while idle; it starts on its emit tick.
        step = r_step;
        if (r_step == ST_IDLE) begin
            n_wait = 1'b0;
            if (i_op == OP_SEND) begin
                n_tx = i_tx_byte;
                step = ST_TX_REQ;
            end else if (i_op == OP_RECV) begin
                n_try   = '0;
                n_bit   = '0;
                n_shift = '0;
                step    = ST_RX_REQ_A;
            end
        end

        // Value driven by each step and line state it waits for.
        unique case (step)
            ST_TX_REQ:    begin value = PV_TX_REQ;                   target = LS_CLR;  end
            ST_TX_LO:     begin value = {1'b0, n_tx[2:0]};           target = LS_BOTH; end
            ST_TX_MID:    begin value = {1'b1, n_tx[5:3]};           target = LS_CLR;  end
            ST_TX_HI:     begin value = {2'b00, n_tx[7:6]};          target = LS_BOTH; end
            ST_RX_REQ_A:  begin value = PV_RX_REQ_A;                 target = LS_CLR;  end
            ST_RX_REQ_B:  begin value = PV_RX_REQ_B;                 target = LS_BOTH; end
            ST_RX_BIT:    begin value = PV_RX_BIT;                   target = LS_ZERO; end
            ST_RX_ACK0:   begin value = PV_ACK0;                     target = LS_BOTH; end
            ST_RX_ACK1_A: begin value = PV_ACK1_A;                   target = LS_CLR;  end
            ST_RX_ACK1_B: begin value = PV_ACK1_B;                   target = LS_ZERO; end
            ST_RX_ACK1_C: begin value = PV_ACK1_C;                   target = LS_BOTH; end
            ST_RX_END:    begin value = PV_RX_BIT;                   target = LS_ZERO; end
            default:      begin value = r_port_latch;                target = LS_ZERO; end
        endcase

        if (step == ST_IDLE) begin
            res.busy_res = 1'b0;
            n_step       = ST_IDLE;
        end else if (!r_wait || r_step == ST_IDLE) begin
            // Emit tick: new low bits go out under the old bit 3.
            res.port_out = {r_port_latch[3], value[2:0]};
            n_port_latch = value;
            n_poll       = '0;
            if (step == ST_RX_END) begin
                res.done_res = 1'b1;
                res.busy_res = 1'b0;
                res.rx_byte  = n_shift;
                n_step       = ST_IDLE;
                n_wait       = 1'b0;
            end else begin
                n_step = step;
                n_wait = 1'b1;
            end
        end else begin
            // Wait tick: drive the full value and sample the partner lines.
            hit = (step == ST_RX_BIT) ? (i_line_state != LS_BOTH)
                                      : (i_line_state == target);
            if (hit) begin
                n_wait = 1'b0;
                unique case (step)
                    ST_TX_REQ:    n_step = ST_TX_LO;
                    ST_TX_LO:     n_step = ST_TX_MID;
                    ST_TX_MID:    n_step = ST_TX_HI;
                    ST_TX_HI: begin
                        res.done_res = 1'b1;
                        res.busy_res = 1'b0;
                        n_step       = ST_IDLE;
                    end
                    ST_RX_REQ_A:  n_step = ST_RX_REQ_B;
                    ST_RX_REQ_B:  n_step = ST_RX_BIT;
                    ST_RX_BIT:    n_step = (i_line_state == LS_CLR) ? ST_RX_ACK0 : ST_RX_ACK1_A;
                    ST_RX_ACK0: begin
                        n_shift = {1'b0, r_shift[7:1]};
                        n_bit   = r_bit + 1'b1;
                        n_step  = (r_bit == 3'd7) ? ST_RX_END : ST_RX_BIT;
                    end
                    ST_RX_ACK1_A: n_step = ST_RX_ACK1_B;
                    ST_RX_ACK1_B: n_step = ST_RX_ACK1_C;
                    ST_RX_ACK1_C: begin
                        n_shift = {1'b1, r_shift[7:1]};
                        n_bit   = r_bit + 1'b1;
                        n_step  = (r_bit == 3'd7) ? ST_RX_END : ST_RX_BIT;
                    end
                    default:      n_step = ST_IDLE;
                endcase
            end else if (poll_out) begin
                if (step == ST_RX_REQ_A || step == ST_RX_REQ_B) begin
                    n_try = try_inc;
                    if (try_inc >= i_request_tries || try_inc == '0) begin
                        res.done_res      = 1'b1;
                        res.timeout_error = 1'b1;
                        res.busy_res      = 1'b0;
                        n_step            = ST_IDLE;
                        n_wait            = 1'b0;
                    end else begin
                        n_step = ST_RX_REQ_A;
                        n_wait = 1'b0;
                    end
                end else begin
                    res.done_res      = 1'b1;
                    res.timeout_error = 1'b1;
                    res.busy_res      = 1'b0;
                    n_step            = ST_IDLE;
                    n_wait            = 1'b0;
                end
            end else begin
                n_poll = r_poll + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ST_IDLE;
            r_wait       <= 1'b0;
            r_port_latch <= '0;
            r_poll       <= '0;
            r_try        <= '0;
            r_bit        <= '0;
            r_shift      <= '0;
            r_tx         <= '0;
        end else if (i_adv) begin
            r_step       <= n_step;
            r_wait       <= n_wait;
            r_port_latch <= n_port_latch;
            r_poll       <= n_poll;
            r_try        <= n_try;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_tx         <= n_tx;
        end
    end

    assign o_res = res;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the nibble handshake byte link. Every input word is
// one tick of the link, and every accepted word produces exactly one result
// word. The bench keeps its own model of the link sequencer. When a word is
// accepted, the model advances and pushes the status word the link should
// return. The checker pops one status per accepted result and compares it
// field by field.
module testbench;
    import nhbl_pkg::*;

    // The link does not decode this op code. It must behave as a plain tick.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Handshake steps of a transfer, in the order the link walks them.
    // Each step emits its new value, then all but the last have wait ticks.
    typedef enum logic [3:0] {
        ST_SEND_REQ,
        ST_SEND_LOW,
        ST_SEND_MID,
        ST_SEND_HIGH,
        ST_RECV_REQ,
        ST_RECV_CONFIRM,
        ST_BIT_WAIT,
        ST_ACK_ZERO,
        ST_ACK_ONE_A,
        ST_ACK_ONE_B,
        ST_ACK_ONE_C,
        ST_RECV_END
    } t_step;

    // One row of the directed table. When typed is set, the status in the row
    // is the expectation. Otherwise the model supplies it.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] tx_byte;
        logic [LINE_W-1:0] line_state;
        logic              typed;
        t_result           status;
    } t_row;

    localparam t_result NO_STATUS = '0;

    // The directed part walks the link from reset through a full send of
    // 0xFF. It also sends a spare op code and sends requests while busy.
    // Then it starts a receive that gets one '0' bit and one '1' bit. The
    // random part picks up that receive where the table leaves it.
    localparam int unsigned N_DIRECTED = 25;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{OP_TICK,  8'h00, 2'd0, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{OP_SPARE, 8'hFF, 2'd3, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{OP_SEND,  8'hFF, 2'd0, 1'b1, '{4'h1, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{OP_RECV,  8'h00, 2'd0, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd2, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd1, 1'b0, NO_STATUS},
        '{OP_SEND,  8'h00, 2'd3, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd0, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd2, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd1, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd3, 1'b1, '{4'h3, 1'b0, 1'b1, 1'b0, 8'h00}},
        '{OP_RECV,  8'hFF, 2'd3, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd2, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd0, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd3, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd0, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd3, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd2, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd0, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd3, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd0, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd1, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd0, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd2, 1'b0, NO_STATUS},
        '{OP_TICK,  8'h00, 2'd0, 1'b0, NO_STATUS}
    };

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_wr_en     = 1'b0;
    logic                i_cfg_index     = CFG_POLL_LIMIT;
    logic [CFG_W-1:0]    i_cfg_data      = '0;
    logic                i_valid         = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_op            = OP_TICK;
    logic [BYTE_W-1:0]   i_tx_byte       = '0;
    logic [LINE_W-1:0]   i_line_state    = '0;
    logic                o_valid;
    logic                i_stall         = 1'b0;
    logic [PORT_W-1:0]   o_port_out;
    logic                o_busy_res;
    logic                o_done_res;
    logic                o_timeout_error;
    logic [BYTE_W-1:0]   o_rx_byte;

    // Idle and stall rates in percent, and the odds that a wait tick gets
    // the line state the link is waiting for.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hit_pct       = 80;
    int unsigned fail_count    = 0;

    // Status words predicted for accepted input words, oldest first.
    t_result link_status_q[$];

    // Model copy of the configuration registers and of the sequencer.
    logic [POLL_W-1:0]  cfg_poll       = POLL_LIMIT_RST;
    logic [TRIES_W-1:0] cfg_tries      = REQUEST_TRIES_RST;
    logic               lk_active      = 1'b0;
    logic               lk_wait        = 1'b0;
    t_step              lk_step        = ST_SEND_REQ;
    logic [PORT_W-1:0]  lk_port        = '0;
    logic [POLL_W-1:0]  lk_polls       = '0;
    logic [TRIES_W-1:0] lk_tries_used  = '0;
    logic [2:0]         lk_bits        = '0;
    logic [BYTE_W-1:0]  lk_shift       = '0;
    logic [BYTE_W-1:0]  lk_tx          = '0;

    nibble_handshake_byte_link dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_tx_byte       (i_tx_byte),
        .i_line_state    (i_line_state),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_port_out      (o_port_out),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_timeout_error (o_timeout_error),
        .o_rx_byte       (o_rx_byte)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Value that the link puts on the data lines for a step.
    function automatic logic [PORT_W-1:0] step_drive(input t_step s,
                                                     input logic [BYTE_W-1:0] tx);
        case (s)
            ST_SEND_REQ:     return 4'h9;
            ST_SEND_LOW:     return {1'b0, tx[2:0]};
            ST_SEND_MID:     return {1'b1, tx[5:3]};
            ST_SEND_HIGH:    return {2'b00, tx[7:6]};
            ST_RECV_REQ:     return 4'hB;
            ST_RECV_CONFIRM: return 4'hF;
            ST_ACK_ZERO:     return 4'hD;
            ST_ACK_ONE_A:    return 4'hE;
            ST_ACK_ONE_B:    return 4'hA;
            ST_ACK_ONE_C:    return 4'h8;
            default:         return 4'hC;
        endcase
    endfunction

    // Partner line state that ends the wait of a step. The bit wait step is
    // handled on its own, because any state other than 3 ends it.
    function automatic logic [LINE_W-1:0] step_target(input t_step s);
        case (s)
            ST_SEND_REQ, ST_SEND_MID, ST_RECV_REQ, ST_ACK_ONE_A: return 2'd2;
            ST_ACK_ONE_B:                                        return 2'd0;
            default:                                             return 2'd3;
        endcase
    endfunction

    task automatic enter_step(input t_step s);
        lk_step = s;
        lk_wait = 1'b0;
    endtask

    // After a bit is acknowledged, go back for the next bit. After the
    // eighth bit, go to the closing 0x0C.
    task automatic finish_bit();
        logic last;
        last    = (lk_bits == 3'd7);
        lk_bits = lk_bits + 1'b1;
        enter_step(last ? ST_RECV_END : ST_BIT_WAIT);
    endtask

    // Moves the model by one tick and returns the status word for that tick.
    task automatic link_tick(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                             input logic [LINE_W-1:0] ls, output t_result r);
        logic [PORT_W-1:0] v;
        logic              hit;
        // A request starts a transfer only while the link is idle.
        if (!lk_active) begin
            if (op == OP_SEND) begin
                lk_tx     = tx;
                lk_active = 1'b1;
                enter_step(ST_SEND_REQ);
            end else if (op == OP_RECV) begin
                lk_tries_used = '0;
                lk_bits       = '0;
                lk_shift      = '0;
                lk_active     = 1'b1;
                enter_step(ST_RECV_REQ);
            end
        end
        r          = '0;
        r.busy_res = 1'b1;
        if (!lk_active) begin
            r.port_out = lk_port;
            r.busy_res = 1'b0;
        end else if (!lk_wait) begin
            // Emit tick: the new low bits go out with the previous bit 3.
            v          = step_drive(lk_step, lk_tx);
            r.port_out = {lk_port[3], v[2:0]};
            lk_port    = v;
            lk_polls   = '0;
            if (lk_step == ST_RECV_END) begin
                r.done_res = 1'b1;
                r.busy_res = 1'b0;
                r.rx_byte  = lk_shift;
                lk_active  = 1'b0;
            end else begin
                lk_wait = 1'b1;
            end
        end else begin
            r.port_out = lk_port;
            hit = (lk_step == ST_BIT_WAIT) ? (ls != 2'd3) : (ls == step_target(lk_step));
            if (hit) begin
                case (lk_step)
                    ST_SEND_HIGH: begin
                        r.done_res = 1'b1;
                        r.busy_res = 1'b0;
                        lk_active  = 1'b0;
                    end
                    ST_BIT_WAIT: enter_step((ls == 2'd2) ? ST_ACK_ZERO : ST_ACK_ONE_A);
                    ST_ACK_ZERO: begin
                        lk_shift = lk_shift >> 1;
                        finish_bit();
                    end
                    ST_ACK_ONE_C: begin
                        lk_shift = {1'b1, lk_shift[7:1]};
                        finish_bit();
                    end
                    default: enter_step(t_step'(lk_step + 1));
                endcase
            end else if ({1'b0, lk_polls} + 17'd1 >= {1'b0, cfg_poll}) begin
                // The wait has timed out. Request steps retry until the
                // try budget runs out, and every other step fails at once.
                // On an error the port keeps its last value.
                if (lk_step == ST_RECV_REQ || lk_step == ST_RECV_CONFIRM) begin
                    lk_tries_used = lk_tries_used + 1'b1;
                    if (lk_tries_used >= cfg_tries || lk_tries_used == '0) begin
                        r.done_res      = 1'b1;
                        r.timeout_error = 1'b1;
                        r.busy_res      = 1'b0;
                        lk_active       = 1'b0;
                    end else begin
                        enter_step(ST_RECV_REQ);
                    end
                end else begin
                    r.done_res      = 1'b1;
                    r.timeout_error = 1'b1;
                    r.busy_res      = 1'b0;
                    lk_active       = 1'b0;
                end
            end else begin
                lk_polls = lk_polls + 1'b1;
            end
        end
    endtask

    // Random word that is shaped to keep transfers moving. An idle link
    // mostly gets send or receive requests. A waiting link gets the awaited
    // line state hit_pct percent of the time, and on other ticks the lines
    // and the op carry noise.
    task automatic pick_word(output logic [OP_W-1:0] op, output logic [BYTE_W-1:0] tx,
                             output logic [LINE_W-1:0] ls);
        op = OP_W'($urandom_range(3));
        tx = BYTE_W'($urandom);
        ls = LINE_W'($urandom_range(3));
        if (!lk_active) begin
            case ($urandom_range(9))
                0:          op = OP_TICK;
                1:          op = OP_SPARE;
                2, 3, 4, 5: op = OP_SEND;
                default:    op = OP_RECV;
            endcase
        end else if (lk_wait && $urandom_range(99) < hit_pct) begin
            ls = (lk_step == ST_BIT_WAIT) ? LINE_W'($urandom_range(2))
                                          : step_target(lk_step);
        end
    endtask

    // Presents one word, holds it through stalls and predicts its status
    // once it is accepted. The caller is always at a rising edge.
    task automatic put_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                            input logic [LINE_W-1:0] ls, input logic typed,
                            input t_result typed_status);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_tx_byte    <= tx;
        i_line_state <= ls;
        do @(posedge i_clk); while (o_stall);
        link_tick(op, tx, ls, predicted);
        link_status_q.push_back(typed ? typed_status : predicted);
    endtask

    // Drops valid and waits until every predicted status has come back.
    // The loop always advances at least one edge, so valid is never
    // lowered and raised in the same step.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (link_status_q.size() != 0);
    endtask

    // Writes both registers while the link is idle and nothing is in
    // flight. The unused upper bits of the tries write carry noise.
    task automatic write_config(input logic [POLL_W-1:0] poll,
                                input logic [TRIES_W-1:0] tries);
        logic [CFG_W-TRIES_W-1:0] junk;
        junk = (CFG_W-TRIES_W)'($urandom);
        hold_until_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_POLL_LIMIT;
        i_cfg_data  <= poll;
        @(posedge i_clk);
        cfg_poll     = poll;
        i_cfg_index <= CFG_REQUEST_TRIES;
        i_cfg_data  <= {junk, tries};
        @(posedge i_clk);
        cfg_tries    = tries;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Result side: stalls at random and checks every accepted result
    // against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        i_stall <= ($urandom_range(99) < stall_pct);
        if (o_valid && !i_stall) begin
            if (link_status_q.size() == 0) begin
                $error("result word arrived with no status pending");
                fail_count++;
            end else begin
                want = link_status_q.pop_front();
                if (o_port_out !== want.port_out) begin
                    $error("port_out: expected %h, got %h", want.port_out, o_port_out);
                    fail_count++;
                end
                if (o_busy_res !== want.busy_res) begin
                    $error("busy_res: expected %b, got %b", want.busy_res, o_busy_res);
                    fail_count++;
                end
                if (o_done_res !== want.done_res) begin
                    $error("done_res: expected %b, got %b", want.done_res, o_done_res);
                    fail_count++;
                end
                if (o_timeout_error !== want.timeout_error) begin
                    $error("timeout_error: expected %b, got %b",
                           want.timeout_error, o_timeout_error);
                    fail_count++;
                end
                if (o_rx_byte !== want.rx_byte) begin
                    $error("rx_byte: expected %h, got %h", want.rx_byte, o_rx_byte);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus. After the directed table come six random phases. Each phase
    // runs under its own register setting and its own idle pattern: no
    // idling, sender idle, receiver stalling, and both lightly. Every phase
    // ends with the link driven back to idle, so that the next setting is
    // written to a quiet link.
    initial begin : stimulus
        logic [OP_W-1:0]    op;
        logic [BYTE_W-1:0]  tx;
        logic [LINE_W-1:0]  ls;
        logic [POLL_W-1:0]  poll;
        logic [TRIES_W-1:0] tries;
        int                 ph;
        int                 n;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < N_DIRECTED; n++) begin
            put_word(DIRECTED[n].op, DIRECTED[n].tx_byte, DIRECTED[n].line_state,
                     DIRECTED[n].typed, DIRECTED[n].status);
        end

        for (ph = 0; ph < 6; ph++) begin
            // Phase 0 keeps the reset setting. The others cover both ends of
            // each register, zero included, and some small random settings
            // that make timeouts and request retries common.
            if (ph != 0) begin
                case (ph)
                    1: begin poll = 16'd1;     tries = 5'd1;  end
                    2: begin poll = 16'hFFFF;  tries = 5'd31; end
                    3: begin poll = 16'd0;     tries = 5'd0;  end
                    4: begin
                        poll  = POLL_W'($urandom_range(2, 6));
                        tries = TRIES_W'($urandom_range(1, 31));
                    end
                    default: begin
                        poll  = POLL_W'($urandom_range(1, 4));
                        tries = TRIES_W'($urandom_range(2, 5));
                    end
                endcase
                write_config(poll, tries);
            end
            send_idle_pct = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 8 : 0;
            stall_pct     = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 8 : 0;
            hit_pct       = 60 + 5 * $urandom_range(4);

            for (n = 0; n < 180; n++) begin
                // Halfway through the long-poll phase, the sender holds off
                // until every pending status has been returned.
                if (ph == 2 && n == 90)
                    hold_until_drained();
                pick_word(op, tx, ls);
                put_word(op, tx, ls, 1'b0, NO_STATUS);
            end

            // Answer every wait until the running transfer completes.
            hit_pct = 100;
            while (lk_active) begin
                pick_word(op, tx, ls);
                put_word(op, tx, ls, 1'b0, NO_STATUS);
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog. A correct run finishes in a small fraction of this time.
    initial begin : watchdog
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
